// File: rtl/core/lru_key_value_store_core_assert.svh
// ---------------------------------------------------------------------------
// LRU key-value store assertion macros
// Shorthand for clocked assertions, disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_STORE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_STORE_CORE_ASSERT_SVH

// check in the same cycle
`define LKV_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lkv assertion failed");

// check in the next cycle
`define LKV_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lkv assertion failed");

`endif

// File: rtl/core/lkv_pkg.sv
// ---------------------------------------------------------------------------
// LRU key-value store package
// Sizes, codes and request, result and entry types of the store.
// ---------------------------------------------------------------------------
package lkv_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W = 5;
  localparam int unsigned CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int unsigned DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;
  localparam logic [DATA_W-1:0] READ_MISS = '1;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic signed [31:0] read_value;
    logic              evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic              load;
    logic [DATA_W-1:0] key;
  } cell_ctrl_t;

endpackage

// File: rtl/core/lkv_cell.sv
// ---------------------------------------------------------------------------
// LRU key-value store cell
// One entry of the recency-ordered chain: compares its key and takes its
// neighbor's entry when told to shift.
// ---------------------------------------------------------------------------
module lkv_cell import lkv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     load_i,
  output entry_t     entry_o,
  output logic       match_o
);

  logic              valid_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      valid_q <= load_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q   <= load_i.key;
      value_q <= load_i.value;
    end
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};
  assign match_o = valid_q && (key_q == ctrl_i.key);

endmodule

// File: rtl/core/lru_key_value_store_core.sv
// ---------------------------------------------------------------------------
// LRU key-value store core
// Fully associative store with least-recently-used replacement.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and raise start; the request is taken at a
//   rising edge where start is high and busy is low. busy stays low, so a
//   request can be issued in every cycle.
//   Result channel: done_o is high for one cycle, the cycle after the
//   request, with rsp_o valid. The receiver cannot stall; take it then.
//   Throughput 1 request per cycle. All key compares run
//   in parallel across the cell chain; a hit or insert moves the entry to
//   the head while the cells in front of it shift back by one.
//   Configuration: cfg_data_i sets the capacity in use (0 acts as 1, above
//   the depth acts as the depth); write only while no request is pending.
//   Reset: the store is empty and the capacity is 16. No clearing pass.
// ---------------------------------------------------------------------------
module lru_key_value_store_core import lkv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  rsp_t             rsp_q, rsp_d;

  entry_t     cell_entry [DEPTH];
  entry_t     cell_load  [DEPTH];
  cell_ctrl_t cell_ctrl  [DEPTH];
  logic [DEPTH-1:0] hit_vec;

  logic              accept;
  logic              hit;
  logic [CNT_W-1:0]  hit_pos;
  logic [DATA_W-1:0] hit_value;
  logic [CMP_W-1:0]  eff_cap;
  logic              evict;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  old_idx;
  logic [CNT_W-1:0]  limit;
  logic              change;
  entry_t            head;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_comb begin
    hit       = 1'b0;
    hit_pos   = '0;
    hit_value = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (hit_vec[i]) begin
        hit       = 1'b1;
        hit_pos   = hit_pos | CNT_W'(i);
        hit_value = hit_value | cell_entry[i].value;
      end
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = CMP_W'(cap_q);
    end
  end

  assign cnt_m1  = count_q - CNT_W'(1);
  assign old_idx = cnt_m1[IDX_W-1:0];
  assign evict   = (req_i.kind == KIND_PUT) && !hit && (CMP_W'(count_q) >= eff_cap);
  assign change  = accept && ((req_i.kind == KIND_PUT) || hit);

  always_comb begin
    if (hit) begin
      limit = hit_pos;
    end else if (evict) begin
      limit = cnt_m1;
    end else begin
      limit = count_q;
    end
  end

  always_comb begin
    head.valid = 1'b1;
    head.key   = req_i.key;
    head.value = (req_i.kind == KIND_PUT) ? req_i.value : hit_value;
  end

  always_comb begin
    count_d = count_q;
    if (accept && (req_i.kind == KIND_PUT) && !hit && !evict) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    rsp_d.found       = hit;
    rsp_d.evicted     = evict;
    rsp_d.evicted_key = evict ? cell_entry[old_idx].key : '0;
    if (req_i.kind == KIND_PUT) begin
      rsp_d.read_value = '0;
    end else if (hit) begin
      rsp_d.read_value = hit_value;
    end else begin
      rsp_d.read_value = READ_MISS;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_load[g] = head;
    end else begin : g_body
      assign cell_load[g] = cell_entry[g-1];
    end
    assign cell_ctrl[g].load = change && (CNT_W'(g) <= limit);
    assign cell_ctrl[g].key  = req_i.key;

    lkv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[g]),
      .load_i  (cell_load[g]),
      .entry_o (cell_entry[g]),
      .match_o (hit_vec[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: rtl/core/lkv_checker.sv
// ---------------------------------------------------------------------------
// LRU key-value store checker
// Port-level checks on request to result timing and result consistency.
// ---------------------------------------------------------------------------
`include "lru_key_value_store_core_assert.svh"

module lkv_checker import lkv_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  `LKV_ASSERT_NEXT(a_req_gives_rsp, start && !busy, done_o)
  `LKV_ASSERT_NEXT(a_no_rsp_unasked, !(start && !busy), !done_o)
  `LKV_ASSERT_SAME(a_evict_only_miss, done_o && rsp_o.evicted, !rsp_o.found)
  `LKV_ASSERT_NEXT(a_get_no_evict, start && !busy && (req_i.kind == KIND_GET),
                   !rsp_o.evicted && (rsp_o.evicted_key == '0))

endmodule

bind lru_key_value_store_core lkv_checker u_lkv_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// File: dv/lru_key_value_store_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU key-value store core testbench
// Drives get and put requests through a directed table and then random
// phases at several capacities and sender idle rates. Each accepted request
// runs through a local LRU predictor; each result is checked field by field
// against the oldest pending lookup.
// ---------------------------------------------------------------------------
module lru_key_value_store_core_tb;
  import lkv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned POOL_N = 24;
  localparam int unsigned PHASE_N = 10;
  localparam int unsigned PHASE_LEN = 125;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   rk;
    logic        kind;
    logic [31:0] key;
    logic [31:0] value;
    logic        typed;
    rsp_t        want;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  req_t             req_i = '0;
  logic             done_o;
  rsp_t             rsp_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i = '0;

  logic row_typed = 1'b0;
  rsp_t row_want = '0;

  logic [31:0]      ent_key [DEPTH];
  logic [31:0]      ent_val [DEPTH];
  int unsigned      ent_rank [DEPTH];
  logic             ent_live [DEPTH];
  int unsigned      live_cnt = 0;
  logic [CAP_W-1:0] cap_reg = CAP_RESET;

  rsp_t        lookup_q [$];
  int unsigned err_cnt = 0;
  int unsigned chk_cnt = 0;
  int unsigned hit_cnt = 0;
  int unsigned miss_cnt = 0;
  int unsigned evict_cnt = 0;
  int unsigned idle_pct = 0;

  logic [31:0] key_pool [POOL_N];
  int          phase_cap [0:PHASE_N-1] = '{16, 1, 0, 31, 5, 8, 2, 12, 16, 3};
  int          phase_idle [0:2] = '{0, 71, 36};
  dir_row_t    dir_tab [$];

  lru_key_value_store_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_key[i] = '0;
      ent_val[i] = '0;
      ent_rank[i] = 0;
      ent_live[i] = 1'b0;
    end
  end

  function automatic void make_newest(int idx);
    for (int j = 0; j < DEPTH; j++) begin
      if (ent_live[j] && ent_rank[j] < ent_rank[idx]) ent_rank[j]++;
    end
    ent_rank[idx] = 0;
  endfunction

  function automatic rsp_t lru_step(req_t r);
    rsp_t        res;
    int          hit;
    int          old;
    int          slot;
    int unsigned cap_eff;
    res = '0;
    hit = -1;
    old = -1;
    slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit < 0 && ent_live[i] && ent_key[i] == r.key) hit = i;
    end
    if (r.kind == KIND_GET) begin
      if (hit >= 0) begin
        res.found = 1'b1;
        res.read_value = ent_val[hit];
        make_newest(hit);
      end else begin
        res.read_value = READ_MISS;
      end
    end else if (hit >= 0) begin
      res.found = 1'b1;
      ent_val[hit] = r.value;
      make_newest(hit);
    end else begin
      cap_eff = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : cap_reg;
      if (live_cnt >= cap_eff) begin
        for (int j = 0; j < DEPTH; j++) begin
          if (ent_live[j] && (old < 0 || ent_rank[j] > ent_rank[old])) old = j;
        end
        if (old >= 0) begin
          res.evicted = 1'b1;
          res.evicted_key = ent_key[old];
          ent_live[old] = 1'b0;
          live_cnt--;
        end
      end
      for (int j = 0; j < DEPTH; j++) begin
        if (slot < 0 && !ent_live[j]) slot = j;
      end
      if (slot >= 0) begin
        for (int k = 0; k < DEPTH; k++) begin
          if (ent_live[k]) ent_rank[k]++;
        end
        ent_key[slot] = r.key;
        ent_val[slot] = r.value;
        ent_rank[slot] = 0;
        ent_live[slot] = 1'b1;
        live_cnt++;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    rsp_t want;
    rsp_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) cap_reg = cfg_data_i;
      if (start && !busy) begin
        want = lru_step(req_i);
        if (row_typed) want = row_want;
        if (want.found) hit_cnt++;
        else miss_cnt++;
        if (want.evicted) evict_cnt++;
        lookup_q.push_back(want);
      end
      if (done_o) begin
        got = rsp_o;
        if (lookup_q.size() == 0) begin
          $display("%0t: result with no request pending: %h", $time, got);
          err_cnt++;
        end else begin
          want = lookup_q.pop_front();
          chk_cnt++;
          if (got !== want) begin
            err_cnt++;
            if (got.found !== want.found)
              $display("%0t: found exp %b got %b", $time, want.found, got.found);
            if (got.read_value !== want.read_value)
              $display("%0t: read_value exp %h got %h", $time, want.read_value,
                       got.read_value);
            if (got.evicted !== want.evicted)
              $display("%0t: evicted exp %b got %b", $time, want.evicted, got.evicted);
            if (got.evicted_key !== want.evicted_key)
              $display("%0t: evicted_key exp %h got %h", $time, want.evicted_key,
                       got.evicted_key);
          end
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic send_req(req_t r, logic typed, rsp_t want);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    row_typed = typed;
    row_want = want;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_lookups();
    @(negedge clk_i);
    start = 1'b0;
    while (lookup_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    drain_lookups();
    cfg_valid_i = 1'b1;
    cfg_data_i = c;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic dir_row_t req_chk(logic kind, logic [31:0] key, logic [31:0] value,
                                       logic f, logic [31:0] rd, logic ev,
                                       logic [31:0] evk);
    dir_row_t d;
    d.rk = ROW_REQ;
    d.kind = kind;
    d.key = key;
    d.value = value;
    d.typed = 1'b1;
    d.want.found = f;
    d.want.read_value = rd;
    d.want.evicted = ev;
    d.want.evicted_key = evk;
    return d;
  endfunction

  function automatic dir_row_t req_pred(logic kind, logic [31:0] key, logic [31:0] value);
    dir_row_t d;
    d = '0;
    d.rk = ROW_REQ;
    d.kind = kind;
    d.key = key;
    d.value = value;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(logic [31:0] c);
    dir_row_t d;
    d = '0;
    d.rk = ROW_CFG;
    d.value = c;
    return d;
  endfunction

  initial begin : stimulus
    req_t        r;
    int unsigned cap_eff;
    int unsigned span;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    dir_tab.push_back(req_chk(KIND_GET, 32'h0000_0000, 32'h0, 0, READ_MISS, 0, 0));
    dir_tab.push_back(req_chk(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
    dir_tab.push_back(req_chk(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF,
                              0, 0));
    dir_tab.push_back(req_chk(KIND_PUT, 32'h8000_0000, 32'h8000_0000, 1, 0, 0, 0));
    dir_tab.push_back(req_chk(KIND_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0));
    dir_tab.push_back(req_chk(KIND_PUT, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0));
    dir_tab.push_back(req_chk(KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 0));
    dir_tab.push_back(req_chk(KIND_GET, 32'h8000_0000, 32'h0, 1, 32'h8000_0000, 0, 0));
    // shrink below the live count: one eviction per insert, count holds
    dir_tab.push_back(cfg_row(2));
    dir_tab.push_back(req_chk(KIND_PUT, 32'h1234_5678, 32'hA5A5_A5A5, 0, 0, 1,
                              32'h7FFF_FFFF));
    dir_tab.push_back(req_chk(KIND_PUT, 32'h5555_5555, 32'h5A5A_5A5A, 0, 0, 1, 0));
    dir_tab.push_back(req_chk(KIND_GET, 32'h7FFF_FFFF, 32'h0, 0, READ_MISS, 0, 0));
    dir_tab.push_back(req_chk(KIND_GET, 32'hFFFF_FFFF, 32'h0, 1, 32'h0000_0001, 0, 0));
    dir_tab.push_back(cfg_row(0));
    dir_tab.push_back(req_chk(KIND_PUT, 32'h0000_0001, 32'hDEAD_BEEF, 0, 0, 1,
                              32'h8000_0000));
    dir_tab.push_back(req_chk(KIND_PUT, 32'h0000_0001, 32'h1357_9BDF, 1, 0, 0, 0));
    dir_tab.push_back(cfg_row(31));
    dir_tab.push_back(req_chk(KIND_PUT, 32'hCAFE_F00D, 32'h2468_ACE0, 0, 0, 0, 0));
    dir_tab.push_back(req_chk(KIND_GET, 32'h0000_0001, 32'h0, 1, 32'h1357_9BDF, 0, 0));
    dir_tab.push_back(req_pred(KIND_GET, 32'h5555_5555, 32'hFFFF_FFFF));
    dir_tab.push_back(cfg_row(1));
    dir_tab.push_back(req_pred(KIND_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
    dir_tab.push_back(cfg_row(16));
    dir_tab.push_back(req_pred(KIND_GET, 32'h0F0F_0F0F, 32'h0));
    dir_tab.push_back(req_pred(KIND_GET, 32'h1234_5678, 32'h0));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].rk == ROW_CFG) begin
        set_capacity(dir_tab[i].value[CAP_W-1:0]);
      end else begin
        r.kind = dir_tab[i].kind;
        r.key = dir_tab[i].key;
        r.value = dir_tab[i].value;
        send_req(r, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom;

    for (int p = 0; p < PHASE_N; p++) begin
      set_capacity(CAP_W'(phase_cap[p]));
      idle_pct = phase_idle[p % 3];
      cap_eff = (phase_cap[p] == 0) ? 1 : (phase_cap[p] > DEPTH) ? DEPTH : phase_cap[p];
      span = (cap_eff + 3 > POOL_N - 1) ? POOL_N - 1 : cap_eff + 3;
      repeat (PHASE_LEN) begin
        r.kind = 1'($urandom_range(1));
        if ($urandom_range(99) < 12) r.key = $urandom;
        else r.key = key_pool[$urandom_range(span)];
        r.value = $urandom;
        if ($urandom_range(99) < 2) key_pool[$urandom_range(POOL_N - 1)] = $urandom;
        send_req(r, 1'b0, '0);
      end
    end

    drain_lookups();
    if (lookup_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, lookup_q.size());
      err_cnt++;
    end
    $display("checked %0d results: %0d hits, %0d misses, %0d evictions",
             chk_cnt, hit_cnt, miss_cnt, evict_cnt);
    $display("capacities 0 to 31 incl. out of range, sender idle 0/36/71 pct");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
